// ===== hw/rtl/itgg_pkg.sv =====
// shared types, constants and codes of the image tile grid generator
// used by every rtl file of the block but itgg_intf, depends on nothing
`default_nettype none

package itgg_pkg;

  // most tiles one image may produce
  localparam int MAX_TILES = 64;

  // queue between the front and back parts
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // iterative divider, one quotient bit per cycle
  localparam int DIV_NUM_W  = 24;
  localparam int DIV_DEN_W  = 13;
  localparam int DIV_STEP_W = $clog2(DIV_NUM_W + 1);
  localparam logic [DIV_STEP_W-1:0] DIV_STEPS = DIV_STEP_W'(DIV_NUM_W);

  // configuration reset values
  localparam logic [11:0]        TILE_SIZE_RST = 12'd32;
  localparam logic [11:0]        COUNT_RST     = 12'd0;
  localparam logic signed [12:0] OFFSET_RST    = -13'sd1;
  localparam logic signed [12:0] GAP_RST       = 13'sd0;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_WIDTH_SMALL = 3'd1,
    ST_COLS_SHORT  = 3'd2,
    ST_HEIGHT_SMALL = 3'd3,
    ST_ROWS_SHORT  = 3'd4,
    ST_NO_SIZE     = 3'd5,
    ST_TOO_MANY    = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    REG_TILE_WIDTH   = 3'd0,
    REG_TILE_HEIGHT  = 3'd1,
    REG_COLUMN_COUNT = 3'd2,
    REG_ROW_COUNT    = 3'd3,
    REG_LEFT_OFFSET  = 3'd4,
    REG_TOP_OFFSET   = 3'd5,
    REG_GAP_X        = 3'd6,
    REG_GAP_Y        = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    FS_IDLE,
    FS_PREP,
    FS_LAUNCH,
    FS_DIV,
    FS_POST,
    FS_MUL,
    FS_TEST,
    FS_CMUL,
    FS_CADD,
    FS_PUSH
  } front_state_t;

  typedef struct packed {
    logic [11:0]        tile_width;
    logic [11:0]        tile_height;
    logic [11:0]        column_count;
    logic [11:0]        row_count;
    logic signed [12:0] left_offset;
    logic signed [12:0] top_offset;
    logic signed [12:0] gap_x;
    logic signed [12:0] gap_y;
  } cfg_t;

  // one resolved grid, or one error
  typedef struct packed {
    status_t     status;
    logic [11:0] w;
    logic [11:0] h;
    logic [6:0]  cols;
    logic [6:0]  total;
    logic [12:0] step_x;
    logic [12:0] step_y;
    logic [16:0] x0;
    logic [16:0] y0;
  } job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/itgg_intf.sv =====
// valid/ready channel interfaces: image beats in, tile beats out
// no dependencies
`default_nettype none

interface itgg_img_if;
  logic               valid;
  logic               ready;
  logic [11:0]        image_width;
  logic [11:0]        image_height;
  logic signed [15:0] base_x;
  logic signed [15:0] base_y;

  modport source (output valid, image_width, image_height, base_x, base_y, input ready);
  modport sink   (input valid, image_width, image_height, base_x, base_y, output ready);
endinterface

interface itgg_tile_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] tile_x;
  logic signed [16:0] tile_y;
  logic [11:0]        out_width;
  logic [11:0]        out_height;
  logic [5:0]         tile_index;
  logic [6:0]         tile_count;
  logic               last;
  logic [2:0]         status;

  modport source (output valid, tile_x, tile_y, out_width, out_height, tile_index,
                  tile_count, last, status, input ready);
  modport sink   (input valid, tile_x, tile_y, out_width, out_height, tile_index,
                  tile_count, last, status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/itgg_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
// depends on itgg_pkg
`default_nettype none

module itgg_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [itgg_pkg::DIV_NUM_W-1:0]   num,
  input  wire logic [itgg_pkg::DIV_DEN_W-1:0]   den,
  output logic                                  done,
  output logic [itgg_pkg::DIV_NUM_W-1:0]        quot
);

  logic                              busy;
  logic [itgg_pkg::DIV_STEP_W-1:0]   step;
  logic [itgg_pkg::DIV_NUM_W-1:0]    q;
  logic [itgg_pkg::DIV_DEN_W-1:0]    rem;
  logic [itgg_pkg::DIV_DEN_W-1:0]    d;
  logic [itgg_pkg::DIV_DEN_W:0]      trial;
  logic [itgg_pkg::DIV_DEN_W+1:0]    diff;

  // remainder stays below the divisor, so the shifted trial fits one extra bit
  assign trial = {rem, q[itgg_pkg::DIV_NUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, d};
  assign quot  = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= itgg_pkg::DIV_STEPS;
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == itgg_pkg::DIV_STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
      d   <= den;
    end else if (busy) begin
      if (!diff[itgg_pkg::DIV_DEN_W+1]) begin
        rem <= diff[itgg_pkg::DIV_DEN_W-1:0];
        q   <= {q[itgg_pkg::DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[itgg_pkg::DIV_DEN_W-1:0];
        q   <= {q[itgg_pkg::DIV_NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/itgg_front.sv =====
// front part: takes an image beat, checks and resolves both grid axes
// with a shared divider, hands one job to the queue; depends on itgg_pkg,
// itgg_intf and itgg_div
`default_nettype none

module itgg_front #(
  parameter int MAX_TILES = itgg_pkg::MAX_TILES
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire itgg_pkg::cfg_t  cfg,
  itgg_img_if.sink             img,
  output logic                 job_valid,
  input  wire logic            job_ready,
  output itgg_pkg::job_t       job
);

  itgg_pkg::front_state_t state, state_next;
  itgg_pkg::status_t      status;
  itgg_pkg::status_t      code_small, code_short;

  logic                 ax;          // 0 works on x, 1 on y
  logic [11:0]          iw, ih;
  logic signed [15:0]   bx, by;
  logic signed [24:0]   num;
  logic [12:0]          den;
  logic [11:0]          size_x, size_y, cnt_x, cnt_y;
  logic [23:0]          total;
  logic [19:0]          prod;
  logic [16:0]          org_x, org_y;

  // per-axis selection
  logic [11:0]          a_img, a_size_reg, a_cnt_reg, a_off, a_size, a_cnt, cnt_eff;
  logic signed [12:0]   a_off_raw, a_gap;
  logic signed [15:0]   a_base;
  logic                 a_center, derived, nosize;

  logic signed [13:0]   avail, sg, fix_num, step_w;
  logic                 fix_small, fix_short;
  logic signed [25:0]   cm1_gap, num_der_w, der_sg;
  logic                 der_small, der_short, post_err, launch_fail, too_many;
  logic signed [20:0]   cen_v, cen_adj, half;
  logic [16:0]          org_w;
  logic [12:0]          step_x_w, step_y_w;

  logic                 div_start, div_done;
  logic [23:0]          quot;

  itgg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num[23:0]),
    .den   (den),
    .done  (div_done),
    .quot  (quot)
  );

  always_comb begin
    a_img      = ax ? ih : iw;
    a_size_reg = ax ? cfg.tile_height : cfg.tile_width;
    a_cnt_reg  = ax ? cfg.row_count : cfg.column_count;
    a_off_raw  = ax ? cfg.top_offset : cfg.left_offset;
    a_gap      = ax ? cfg.gap_y : cfg.gap_x;
    a_base     = ax ? by : bx;
    a_size     = ax ? size_y : size_x;
    a_cnt      = ax ? cnt_y : cnt_x;
    a_center   = a_off_raw[12];
    a_off      = a_center ? 12'd0 : a_off_raw[11:0];
    derived    = (a_size_reg == 12'd0);
    cnt_eff    = (a_cnt_reg == 12'd0) ? 12'd1 : a_cnt_reg;
    nosize     = (cfg.tile_width == 12'd0) && (cfg.tile_height == 12'd0) &&
                 (cfg.column_count == 12'd0) && (cfg.row_count == 12'd0);
    if (ax) begin
      code_small = itgg_pkg::ST_HEIGHT_SMALL;
      code_short = itgg_pkg::ST_ROWS_SHORT;
    end else begin
      code_small = itgg_pkg::ST_WIDTH_SMALL;
      code_short = itgg_pkg::ST_COLS_SHORT;
    end
  end

  // room left for tiles after the fixed offset
  assign avail = $signed({2'b00, a_img}) - $signed({2'b00, a_off});

  // fixed tile size
  assign sg        = $signed({2'b00, a_size_reg}) + 14'(a_gap);
  assign fix_small = (sg <= 14'sd0);
  assign fix_short = ($signed({2'b00, a_size_reg}) > avail);
  assign fix_num   = avail - $signed({2'b00, a_size_reg});

  // size from tile count
  assign cm1_gap   = $signed({1'b0, cnt_eff - 12'd1}) * a_gap;
  assign num_der_w = 26'(avail) - cm1_gap;
  assign launch_fail = derived && (num[24] || (num == '0));

  assign der_sg    = $signed({2'b00, quot}) + 26'(a_gap);
  assign der_small = (quot == '0) || (der_sg <= 26'sd0);
  assign der_short = ($signed({2'b00, quot}) > 26'(avail));
  assign post_err  = derived && (der_small || der_short);

  assign too_many  = (total > 24'(MAX_TILES));

  // centering: (image - count*(size+gap) + gap) / 2 toward zero
  assign step_w  = $signed({2'b00, a_size}) + 14'(a_gap);
  assign cen_v   = $signed({9'd0, a_img}) - $signed({1'b0, prod}) + 21'(a_gap);
  assign cen_adj = cen_v + $signed({20'd0, cen_v[20]});
  assign half    = cen_adj >>> 1;
  assign org_w   = a_center ? (half[16:0] + 17'(a_base)) : ({5'd0, a_off} + 17'(a_base));

  assign step_x_w = {1'b0, size_x} + cfg.gap_x[12:0];
  assign step_y_w = {1'b0, size_y} + cfg.gap_y[12:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      itgg_pkg::FS_IDLE: begin
        if (img.valid) begin
          state_next = nosize ? itgg_pkg::FS_PUSH : itgg_pkg::FS_PREP;
        end
      end
      itgg_pkg::FS_PREP: begin
        if (!derived && (fix_small || fix_short)) begin
          state_next = itgg_pkg::FS_PUSH;
        end else begin
          state_next = itgg_pkg::FS_LAUNCH;
        end
      end
      itgg_pkg::FS_LAUNCH: begin
        state_next = launch_fail ? itgg_pkg::FS_PUSH : itgg_pkg::FS_DIV;
      end
      itgg_pkg::FS_DIV: begin
        if (div_done) begin
          state_next = itgg_pkg::FS_POST;
        end
      end
      itgg_pkg::FS_POST: begin
        if (post_err) begin
          state_next = itgg_pkg::FS_PUSH;
        end else begin
          state_next = ax ? itgg_pkg::FS_MUL : itgg_pkg::FS_PREP;
        end
      end
      itgg_pkg::FS_MUL: begin
        state_next = itgg_pkg::FS_TEST;
      end
      itgg_pkg::FS_TEST: begin
        state_next = too_many ? itgg_pkg::FS_PUSH : itgg_pkg::FS_CMUL;
      end
      itgg_pkg::FS_CMUL: begin
        state_next = itgg_pkg::FS_CADD;
      end
      itgg_pkg::FS_CADD: begin
        state_next = ax ? itgg_pkg::FS_PUSH : itgg_pkg::FS_CMUL;
      end
      itgg_pkg::FS_PUSH: begin
        if (job_ready) begin
          state_next = itgg_pkg::FS_IDLE;
        end
      end
      default: begin
        state_next = itgg_pkg::FS_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    img.ready = (state == itgg_pkg::FS_IDLE) && !rst;
    div_start = (state == itgg_pkg::FS_LAUNCH) && !launch_fail;
    job_valid = (state == itgg_pkg::FS_PUSH);
  end

  always_comb begin
    job        = '0;
    job.status = status;
    if (status == itgg_pkg::ST_OK) begin
      job.w      = size_x;
      job.h      = size_y;
      job.cols   = cnt_x[6:0];
      job.total  = total[6:0];
      job.step_x = step_x_w;
      job.step_y = step_y_w;
      job.x0     = org_x;
      job.y0     = org_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itgg_pkg::FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      itgg_pkg::FS_IDLE: begin
        if (img.valid) begin
          iw <= img.image_width;
          ih <= img.image_height;
          bx <= img.base_x;
          by <= img.base_y;
          ax <= 1'b0;
          if (nosize) begin
            status <= itgg_pkg::ST_NO_SIZE;
          end else begin
            status <= itgg_pkg::ST_OK;
          end
        end
      end
      itgg_pkg::FS_PREP: begin
        if (derived) begin
          num <= num_der_w[24:0];
          den <= {1'b0, cnt_eff};
        end else begin
          num <= 25'(fix_num);
          den <= sg[12:0];
          if (fix_small) begin
            status <= code_small;
          end else if (fix_short) begin
            status <= code_short;
          end
        end
      end
      itgg_pkg::FS_LAUNCH: begin
        if (launch_fail) begin
          status <= code_small;
        end
      end
      itgg_pkg::FS_DIV: begin
      end
      itgg_pkg::FS_POST: begin
        if (derived) begin
          if (der_small) begin
            status <= code_small;
          end else if (der_short) begin
            status <= code_short;
          end
        end
        if (!post_err) begin
          if (ax) begin
            size_y <= derived ? quot[11:0] : a_size_reg;
            cnt_y  <= derived ? cnt_eff : quot[11:0] + 12'd1;
          end else begin
            size_x <= derived ? quot[11:0] : a_size_reg;
            cnt_x  <= derived ? cnt_eff : quot[11:0] + 12'd1;
            ax     <= 1'b1;
          end
        end
      end
      itgg_pkg::FS_MUL: begin
        total <= cnt_x * cnt_y;
      end
      itgg_pkg::FS_TEST: begin
        if (too_many) begin
          status <= itgg_pkg::ST_TOO_MANY;
        end else begin
          ax <= 1'b0;
        end
      end
      itgg_pkg::FS_CMUL: begin
        prod <= a_cnt[6:0] * step_w[12:0];
      end
      itgg_pkg::FS_CADD: begin
        if (ax) begin
          org_y <= org_w;
        end else begin
          org_x <= org_w;
          ax    <= 1'b1;
        end
      end
      itgg_pkg::FS_PUSH: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/itgg_queue.sv =====
// small job queue between the front and back parts
// depends on itgg_pkg
`default_nettype none

module itgg_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire itgg_pkg::job_t  in_job,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output itgg_pkg::job_t       out_job
);

  itgg_pkg::job_t                   slots [itgg_pkg::QUEUE_DEPTH];
  logic [itgg_pkg::QPTR_W-1:0]      wr_ptr, rd_ptr;
  logic [itgg_pkg::QCNT_W-1:0]      fill;
  logic                             push, pop;

  assign in_ready  = (fill != itgg_pkg::QCNT_W'(itgg_pkg::QUEUE_DEPTH));
  assign out_valid = (fill != '0);
  assign out_job   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_job;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/itgg_back.sv =====
// back part: walks one job row-major and drives tile beats through an
// output register; depends on itgg_pkg and itgg_intf
`default_nettype none

module itgg_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            job_valid,
  output logic                 job_ready,
  input  wire itgg_pkg::job_t  job,
  itgg_tile_if.source          tile
);

  itgg_pkg::job_t cur;
  logic           busy;
  logic [6:0]     col;
  logic [5:0]     idx;
  logic [16:0]    x, y;
  logic           load, emit, is_last;

  assign load      = !busy && job_valid;
  assign job_ready = load;
  assign emit      = busy && (!tile.valid || tile.ready);
  // an error job is a single beat
  assign is_last   = (cur.status != itgg_pkg::ST_OK) || (({1'b0, idx} + 7'd1) == cur.total);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      tile.valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
      end else if (emit && is_last) begin
        busy <= 1'b0;
      end
      if (emit) begin
        tile.valid <= 1'b1;
      end else if (tile.ready) begin
        tile.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= job;
      col <= '0;
      idx <= '0;
      x   <= job.x0;
      y   <= job.y0;
    end else if (emit && !is_last) begin
      idx <= idx + 6'd1;
      if ((col + 7'd1) == cur.cols) begin
        col <= '0;
        x   <= cur.x0;
        y   <= y + {4'd0, cur.step_y};
      end else begin
        col <= col + 7'd1;
        x   <= x + {4'd0, cur.step_x};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      tile.tile_x     <= x;
      tile.tile_y     <= y;
      tile.out_width  <= cur.w;
      tile.out_height <= cur.h;
      tile.tile_index <= idx;
      tile.tile_count <= cur.total;
      tile.last       <= is_last;
      tile.status     <= cur.status;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/image_tile_grid_generator_core.sv =====
// top level of the image tile grid generator: configuration registers,
// front, job queue and back; depends on itgg_pkg, itgg_intf, itgg_div,
// itgg_front, itgg_queue and itgg_back
`default_nettype none

// One image beat (width, height, base location) produces a row-major run of
// tile beats, each with its rectangle, index, the image's tile count and a
// last flag, or a single error beat with a status code and last set. Tile
// sizes come from the tile_width/tile_height registers or are derived from
// column_count/row_count and the gap; a negative offset centers the grid.
// When both axes pass, the front resolves an image in order: each axis runs
// the shared 24-step restoring divider, then the tile count test follows and
// a multiply and an add give each axis its origin; a failed check ends it
// early. The back then emits one tile beat per cycle while the output is
// taken, and picks up the next job only after the last beat of the current
// one. A two-entry job queue sits between the two, so the front
// resolves the next image while the back is still emitting. Results leave
// through an output register; while a finished beat waits to be taken, the
// front keeps accepting and resolving images until the job queue is full.
// Registers are written through cfg_write, cfg_index and cfg_data and must
// only change while the block is idle.
module image_tile_grid_generator_core #(
  parameter int MAX_TILES = itgg_pkg::MAX_TILES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  itgg_img_if.sink         img,
  itgg_tile_if.source      tile
);

  itgg_pkg::cfg_t cfg;

  // front to queue
  logic           fq_valid, fq_ready;
  itgg_pkg::job_t fq_job;
  // queue to back
  logic           qb_valid, qb_ready;
  itgg_pkg::job_t qb_job;

  // configuration registers, reset to their documented defaults
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tile_width   <= itgg_pkg::TILE_SIZE_RST;
      cfg.tile_height  <= itgg_pkg::TILE_SIZE_RST;
      cfg.column_count <= itgg_pkg::COUNT_RST;
      cfg.row_count    <= itgg_pkg::COUNT_RST;
      cfg.left_offset  <= itgg_pkg::OFFSET_RST;
      cfg.top_offset   <= itgg_pkg::OFFSET_RST;
      cfg.gap_x        <= itgg_pkg::GAP_RST;
      cfg.gap_y        <= itgg_pkg::GAP_RST;
    end else if (cfg_write) begin
      unique case (itgg_pkg::cfg_reg_t'(cfg_index))
        itgg_pkg::REG_TILE_WIDTH:   cfg.tile_width   <= cfg_data[11:0];
        itgg_pkg::REG_TILE_HEIGHT:  cfg.tile_height  <= cfg_data[11:0];
        itgg_pkg::REG_COLUMN_COUNT: cfg.column_count <= cfg_data[11:0];
        itgg_pkg::REG_ROW_COUNT:    cfg.row_count    <= cfg_data[11:0];
        itgg_pkg::REG_LEFT_OFFSET:  cfg.left_offset  <= cfg_data;
        itgg_pkg::REG_TOP_OFFSET:   cfg.top_offset   <= cfg_data;
        itgg_pkg::REG_GAP_X:        cfg.gap_x        <= cfg_data;
        itgg_pkg::REG_GAP_Y:        cfg.gap_y        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // checks, divisions and centering for one image at a time
  itgg_front #(
    .MAX_TILES (MAX_TILES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .img       (img),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  // decouples the resolving front from the emitting back
  itgg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_job    (fq_job),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_job   (qb_job)
  );

  // one tile beat per cycle while the output is taken, row-major
  itgg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .tile      (tile)
  );

  // an error is reported as one closing beat with a zero count
  a_error_single: assert property (@(posedge clk) disable iff (rst)
    (tile.valid && (tile.status != itgg_pkg::ST_OK)) |-> (tile.last && (tile.tile_count == 7'd0)))
    else $error("error beat not closing or count not zero");

  // the closing tile of a grid carries the highest index
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (tile.valid && tile.last && (tile.status == itgg_pkg::ST_OK))
      |-> (({1'b0, tile.tile_index} + 7'd1) == tile.tile_count))
    else $error("last tile index does not match tile count");

  // tile indexes stay inside the grid
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (tile.valid && (tile.status == itgg_pkg::ST_OK))
      |-> ({1'b0, tile.tile_index} < tile.tile_count))
    else $error("tile index beyond tile count");

  // the queue never sees a job offered to a full queue being lost
  a_front_holds: assert property (@(posedge clk) disable iff (rst)
    (fq_valid && !fq_ready) |=> (fq_valid && $stable(fq_job)))
    else $error("front dropped or changed a waiting job");

endmodule

`default_nettype wire
